@@ rtl/core/vfc_pkg.sv @@
// Shared types and constants for the voxel face culling block.
// Used by all rtl/core modules but vfc_ram and by the testbench; depends on nothing else.
package vfc_pkg;

    // Default chunk edge: 2**LOG_SIZE voxels.
    localparam int LOG_SIZE_DEF = 4;

    // Fixed field widths of the request and face record.
    localparam int MODE_W  = 2;
    localparam int COORD_W = 4;
    localparam int SIDE_W  = 3;
    localparam int TYPE_W  = 8;
    localparam int DIR_W   = 3;

    // Number of face directions.
    localparam int NUM_DIRS = 6;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_WR_VOXEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_NBR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;

    // Face directions and neighbour layer codes.
    localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd2;
    localparam logic [DIR_W-1:0] DIR_TOP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_BACK   = 3'd5;
    localparam logic [DIR_W-1:0] DIR_DONE   = 3'd6;

    // Request payload.
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [SIDE_W-1:0]  side;
        logic [TYPE_W-1:0]  block_type;
    } vfc_req_t;

    // Face record payload.
    typedef struct packed {
        logic [COORD_W-1:0] face_x;
        logic [COORD_W-1:0] face_y;
        logic [COORD_W-1:0] face_z;
        logic [SIDE_W-1:0]  face_side;
        logic [TYPE_W-1:0]  face_type;
        logic               last_face;
    } vfc_face_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             scan;
        logic [DIR_W-1:0] dir;
        logic             emit;
    } vfc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic center_air;
        logic mask_empty;
        logic out_free;
        logic emit_last;
    } vfc_stat_t;

endpackage

@@ rtl/core/vfc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package dependency.
module vfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/vfc_datapath.sv @@
// Datapath: request registers, voxel and neighbour stores, air mask and face output register.
// Depends on vfc_pkg and vfc_ram.
module vfc_datapath #(
    parameter int LOG_SIZE = vfc_pkg::LOG_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vfc_pkg::vfc_req_t  req,
    input  vfc_pkg::vfc_cmd_t  cmd,
    output vfc_pkg::vfc_stat_t stat,
    output vfc_pkg::vfc_face_t face,
    output logic               face_valid,
    input  logic               face_stall
);
    import vfc_pkg::*;

    localparam int CW        = LOG_SIZE;
    localparam int VA_W      = 3 * LOG_SIZE;
    localparam int NA_W      = DIR_W + 2 * LOG_SIZE;
    localparam int VOX_DEPTH = 1 << VA_W;
    localparam int NBR_DEPTH = 1 << NA_W;
    localparam logic [CW-1:0] CMAX = '1;

    logic [CW-1:0] in_x, in_y, in_z;
    logic [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [TYPE_W-1:0] type_reg;
    logic bnd_reg;
    logic [NUM_DIRS-1:0] mask_reg, mask_next, mask_clr;
    logic [DIR_W-1:0] sel_dir;
    logic emit_last;
    logic air;
    vfc_face_t face_reg;
    logic face_valid_reg, face_valid_next;

    logic [CW-1:0] nx, ny, nz, pa, pb, wa, wb;
    logic bnd;

    logic vox_we, nbr_we;
    logic [VA_W-1:0] vox_waddr, vox_raddr;
    logic [NA_W-1:0] nbr_waddr, nbr_raddr;
    logic [TYPE_W-1:0] vox_rdata;
    logic [0:0] nbr_rdata;

    assign in_x = CW'(req.x);
    assign in_y = CW'(req.y);
    assign in_z = CW'(req.z);

    // In-plane coordinates of a neighbour boundary write.
    always_comb
    begin
        wa = in_x;
        wb = in_y;
        case (req.side) inside
            DIR_LEFT, DIR_RIGHT:
            begin
                wa = in_y;
                wb = in_z;
            end
            DIR_BOTTOM, DIR_TOP:
            begin
                wa = in_x;
                wb = in_z;
            end
            default:
            begin
                wa = in_x;
                wb = in_y;
            end
        endcase
    end

    // Store writes happen at the accepting edge.
    assign vox_we    = cmd.accept && (req.mode == MODE_WR_VOXEL);
    assign nbr_we    = cmd.accept && (req.mode == MODE_WR_NBR) && (req.side <= DIR_BACK);
    assign vox_waddr = {in_x, in_y, in_z};
    assign nbr_waddr = {req.side, wa, wb};

    // Neighbour cell coordinates and boundary test for the scanned direction.
    always_comb
    begin
        nx  = cx_reg;
        ny  = cy_reg;
        nz  = cz_reg;
        pa  = cx_reg;
        pb  = cy_reg;
        bnd = 1'b0;
        case (cmd.dir)
            DIR_LEFT:
            begin
                nx  = cx_reg - CW'(1);
                bnd = (cx_reg == '0);
                pa  = cy_reg;
                pb  = cz_reg;
            end
            DIR_RIGHT:
            begin
                nx  = cx_reg + CW'(1);
                bnd = (cx_reg == CMAX);
                pa  = cy_reg;
                pb  = cz_reg;
            end
            DIR_BOTTOM:
            begin
                ny  = cy_reg - CW'(1);
                bnd = (cy_reg == '0);
                pb  = cz_reg;
            end
            DIR_TOP:
            begin
                ny  = cy_reg + CW'(1);
                bnd = (cy_reg == CMAX);
                pb  = cz_reg;
            end
            DIR_FRONT:
            begin
                nz  = cz_reg - CW'(1);
                bnd = (cz_reg == '0);
            end
            DIR_BACK:
            begin
                nz  = cz_reg + CW'(1);
                bnd = (cz_reg == CMAX);
            end
            default:
            begin
                bnd = 1'b0;
            end
        endcase
    end

    // The center voxel is read in the accept cycle, then one neighbour per cycle.
    assign vox_raddr = cmd.accept ? {in_x, in_y, in_z} : {nx, ny, nz};
    assign nbr_raddr = {cmd.dir, pa, pb};

    vfc_ram #(
        .WIDTH(TYPE_W),
        .DEPTH(VOX_DEPTH)
    ) u_vox_ram (
        .clk  (clk),
        .we   (vox_we),
        .waddr(vox_waddr),
        .wdata(req.block_type),
        .raddr(vox_raddr),
        .rdata(vox_rdata)
    );

    vfc_ram #(
        .WIDTH(1),
        .DEPTH(NBR_DEPTH)
    ) u_nbr_ram (
        .clk  (clk),
        .we   (nbr_we),
        .waddr(nbr_waddr),
        .wdata(req.block_type == '0),
        .raddr(nbr_raddr),
        .rdata(nbr_rdata)
    );

    // Air test on the data of the direction read in the previous cycle.
    assign air = bnd_reg ? nbr_rdata[0] : (vox_rdata == '0);

    // Lowest pending direction is emitted first.
    always_comb
    begin
        sel_dir = '0;
        for (int i = NUM_DIRS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel_dir = DIR_W'(i);
            end
        end
        mask_clr          = mask_reg;
        mask_clr[sel_dir] = 1'b0;
        emit_last         = (mask_clr == '0);
    end

    // Air mask update during the scan and while emitting.
    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.scan)
        begin
            if (cmd.dir == DIR_LEFT)
            begin
                mask_next = '0;
            end
            for (int i = 0; i < NUM_DIRS; i++)
            begin
                if (cmd.dir == DIR_W'(i + 1))
                begin
                    mask_next[i] = air;
                end
            end
        end
        else if (cmd.emit)
        begin
            mask_next = mask_clr;
        end
    end

    // Output register valid: loads on emit, clears when taken.
    always_comb
    begin
        if (cmd.emit)
        begin
            face_valid_next = 1'b1;
        end
        else if (!face_stall)
        begin
            face_valid_next = 1'b0;
        end
        else
        begin
            face_valid_next = face_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= '0;
            face_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg       <= mask_next;
            face_valid_reg <= face_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cx_reg <= in_x;
            cy_reg <= in_y;
            cz_reg <= in_z;
        end
        if (cmd.scan)
        begin
            bnd_reg <= bnd;
            if (cmd.dir == DIR_LEFT)
            begin
                type_reg <= vox_rdata;
            end
        end
        if (cmd.emit)
        begin
            face_reg.face_x    <= COORD_W'(cx_reg);
            face_reg.face_y    <= COORD_W'(cy_reg);
            face_reg.face_z    <= COORD_W'(cz_reg);
            face_reg.face_side <= sel_dir;
            face_reg.face_type <= type_reg;
            face_reg.last_face <= emit_last;
        end
    end

    // Status toward the controller.
    assign stat.is_query   = (req.mode == MODE_QUERY);
    assign stat.center_air = (vox_rdata == '0);
    assign stat.mask_empty = (mask_next == '0);
    assign stat.out_free   = !face_valid_reg || !face_stall;
    assign stat.emit_last  = emit_last;

    assign face       = face_reg;
    assign face_valid = face_valid_reg;

endmodule

@@ rtl/core/vfc_ctrl.sv @@
// Controller: state machine that sequences writes, the neighbour scan and face emission.
// Depends on vfc_pkg.
module vfc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  vfc_pkg::vfc_stat_t stat,
    output vfc_pkg::vfc_cmd_t  cmd
);
    import vfc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [DIR_W-1:0] dir_reg, dir_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        dir_next   = dir_reg;
        cmd.accept = 1'b0;
        cmd.scan   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.dir    = dir_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = req_valid;
                if (req_valid && stat.is_query)
                begin
                    state_next = ST_SCAN;
                    dir_next   = DIR_LEFT;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if ((dir_reg == DIR_LEFT) && stat.center_air)
                begin
                    state_next = ST_IDLE;
                end
                else if (dir_reg == DIR_DONE)
                begin
                    state_next = stat.mask_empty ? ST_IDLE : ST_EMIT;
                end
                else
                begin
                    dir_next = dir_reg + DIR_W'(1);
                end
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
                if (stat.out_free && stat.emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dir_reg   <= DIR_LEFT;
        end
        else
        begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
        end
    end

endmodule

@@ rtl/core/voxel_face_culling_top.sv @@
// Voxel face culling top level: controller plus datapath with the two stores.
// Depends on vfc_pkg, vfc_ctrl, vfc_datapath and vfc_ram.
//
// A voxel write or a neighbour boundary write is accepted in the idle state and
// does not hold off the next request. A query reads the voxel and then its six
// neighbours in turn, because each store has a single read port and one neighbour
// is read per cycle, and then emits its face records (up to six) while the output
// is not stalled. A query on an air voxel ends as soon as the voxel itself is read.
// The last face record of a query may wait in the output register while the next
// request is accepted. The stores are not cleared after reset; an entry must be
// written before it is read.
module voxel_face_culling_top #(
    parameter int LOG_SIZE = vfc_pkg::LOG_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  vfc_pkg::vfc_req_t  req,
    output logic               face_valid,
    input  logic               face_stall,
    output vfc_pkg::vfc_face_t face
);
    import vfc_pkg::*;

    vfc_cmd_t  cmd;
    vfc_stat_t stat;

    vfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    vfc_datapath #(
        .LOG_SIZE(LOG_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .face      (face),
        .face_valid(face_valid),
        .face_stall(face_stall)
    );

    // A face always belongs to a solid voxel.
    assert property (@(posedge clk) disable iff (!rst_n)
        face_valid |-> (face.face_type != '0))
        else $error("face record with air type");

    // Records of one query come in rising direction order, back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        face_valid && !face_stall && !face.last_face
        |=> face_valid && (face.face_side > $past(face.face_side)))
        else $error("face records out of order or missing");

    // Emitting the last record frees the request side.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && stat.emit_last |=> !req_stall)
        else $error("request side not released after last record");

    // An accepted query holds off further requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (req.mode == MODE_QUERY) |=> req_stall)
        else $error("request accepted during a query");

endmodule

@@ test/tb_voxel_face_culling_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for voxel_face_culling_top: directed and random requests,
// an in-bench face predictor, and in-order record checking. Depends on vfc_pkg.
module tb_voxel_face_culling_top;
    import vfc_pkg::*;

    localparam int          LOG_SIZE     = LOG_SIZE_DEF;
    localparam int unsigned EDGE_MAX     = (1 << LOG_SIZE) - 1;
    localparam int unsigned VOXELS       = 1 << (3 * LOG_SIZE);
    localparam int unsigned LAYER        = 1 << (2 * LOG_SIZE);
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [SIDE_W-1:0] SIDE_UNUSED = 3'd7;
    localparam int          ITEM_TARGET  = 370;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          HOLD_AT_FACE = 12;
    localparam int          DRAIN_CYCLES = 40;
    localparam longint      TIMEOUT_NS   = 4_000_000;

    logic      clk;
    logic      rst_n      = 1'b0;
    logic      req_valid  = 1'b0;
    logic      req_stall;
    vfc_req_t  req        = '0;
    logic      face_valid;
    logic      face_stall = 1'b0;
    vfc_face_t face;

    voxel_face_culling_top #(
        .LOG_SIZE (LOG_SIZE)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .face_valid (face_valid),
        .face_stall (face_stall),
        .face       (face)
    );

    // Predicted contents of the two stores.
    logic [TYPE_W-1:0] chunk_types [VOXELS];
    bit                layer_air   [6 * LAYER];

    // Which entries the stimulus has written so far, so no query reads a blank one.
    bit chunk_written [VOXELS];
    bit layer_written [6 * LAYER];

    vfc_req_t  pending_reqs[$];
    vfc_face_t expected_faces[$];

    int counted_items = 0;
    int errors        = 0;
    int sent_items    = 0;
    int n_queries     = 0;
    int n_writes      = 0;
    int n_ignored     = 0;
    int faces_seen    = 0;
    int tx_gap        = 0;
    int rx_wait       = 0;
    bit hold_done     = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned voxel_addr(int unsigned x, int unsigned y, int unsigned z);
        return ((x & EDGE_MAX) << (2 * LOG_SIZE)) | ((y & EDGE_MAX) << LOG_SIZE) | (z & EDGE_MAX);
    endfunction

    // Boundary cell of layer s that lines up with voxel (x,y,z).
    function automatic int unsigned layer_addr(int unsigned s, int unsigned x, int unsigned y,
                                               int unsigned z);
        int unsigned a;
        int unsigned b;
        if (s < 2)
        begin
            a = y;
            b = z;
        end
        else if (s < 4)
        begin
            a = x;
            b = z;
        end
        else
        begin
            a = x;
            b = y;
        end
        return s * LAYER + (((a & EDGE_MAX) << LOG_SIZE) | (b & EDGE_MAX));
    endfunction

    // Finds the cell one step from (x,y,z) in direction dir: either a chunk voxel
    // at (nx,ny,nz) or, on the chunk boundary, a cell of the neighbour layer.
    task automatic locate_neighbour(input int unsigned x, input int unsigned y,
                                    input int unsigned z, input logic [DIR_W-1:0] dir,
                                    output bit on_layer, output int unsigned nx,
                                    output int unsigned ny, output int unsigned nz,
                                    output int unsigned addr);
        nx = x;
        ny = y;
        nz = z;
        on_layer = 1'b0;
        case (dir)
            DIR_LEFT:
            begin
                on_layer = (x == 0);
                nx = x - 1;
            end
            DIR_RIGHT:
            begin
                on_layer = (x == EDGE_MAX);
                nx = x + 1;
            end
            DIR_BOTTOM:
            begin
                on_layer = (y == 0);
                ny = y - 1;
            end
            DIR_TOP:
            begin
                on_layer = (y == EDGE_MAX);
                ny = y + 1;
            end
            DIR_FRONT:
            begin
                on_layer = (z == 0);
                nz = z - 1;
            end
            default:
            begin
                on_layer = (z == EDGE_MAX);
                nz = z + 1;
            end
        endcase
        addr = on_layer ? layer_addr(int'(dir), x, y, z) : voxel_addr(nx, ny, nz);
    endtask

    // Updates the predicted stores for one accepted request and, for a query,
    // appends the face records it should produce.
    task automatic apply_request(input vfc_req_t r);
        int unsigned       x;
        int unsigned       y;
        int unsigned       z;
        int unsigned       nx;
        int unsigned       ny;
        int unsigned       nz;
        int unsigned       addr;
        bit                on_layer;
        logic [TYPE_W-1:0] center;
        logic [NUM_DIRS-1:0] open_dirs;
        int                last_dir;
        vfc_face_t         rec;
        x = r.x & EDGE_MAX;
        y = r.y & EDGE_MAX;
        z = r.z & EDGE_MAX;
        case (r.mode)
            MODE_WR_VOXEL:
                chunk_types[voxel_addr(x, y, z)] = r.block_type;
            MODE_WR_NBR:
                if (r.side <= DIR_BACK)
                    layer_air[layer_addr(int'(r.side), x, y, z)] = (r.block_type == '0);
            MODE_QUERY:
            begin
                center = chunk_types[voxel_addr(x, y, z)];
                if (center != '0)
                begin
                    open_dirs = '0;
                    last_dir  = -1;
                    for (int d = 0; d < NUM_DIRS; d++)
                    begin
                        locate_neighbour(x, y, z, DIR_W'(d), on_layer, nx, ny, nz, addr);
                        open_dirs[d] = on_layer ? layer_air[addr] : (chunk_types[addr] == '0);
                        if (open_dirs[d])
                            last_dir = d;
                    end
                    for (int d = 0; d < NUM_DIRS; d++)
                    begin
                        if (open_dirs[d])
                        begin
                            rec.face_x    = COORD_W'(x);
                            rec.face_y    = COORD_W'(y);
                            rec.face_z    = COORD_W'(z);
                            rec.face_side = SIDE_W'(d);
                            rec.face_type = center;
                            rec.last_face = (d == last_dir);
                            expected_faces.push_back(rec);
                        end
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    // Random wait for one request or record; every fourth run of 32 has none.
    function automatic int idle_draw(int n);
        if (((n / 32) % 4) == 3)
            return 0;
        return int'($urandom_range(0, 9));
    endfunction

    // Coordinates cluster at both chunk edges so stores get reused and boundaries hit.
    function automatic int unsigned pick_coord();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, 2);
        if (r < 8)
            return $urandom_range(EDGE_MAX - 2, EDGE_MAX);
        return $urandom_range(0, EDGE_MAX);
    endfunction

    function automatic logic [TYPE_W-1:0] pick_type(int air_pct);
        if (int'($urandom_range(0, 99)) < air_pct)
            return '0;
        return TYPE_W'($urandom_range(1, 255));
    endfunction

    function automatic logic [SIDE_W-1:0] pick_side();
        return SIDE_W'($urandom_range(0, 5));
    endfunction

    // Appends one request and records which store entry it fills.
    task automatic queue_request(input logic [MODE_W-1:0] mode, input int unsigned x,
                                 input int unsigned y, input int unsigned z,
                                 input logic [SIDE_W-1:0] side,
                                 input logic [TYPE_W-1:0] btype);
        vfc_req_t r;
        r.mode       = mode;
        r.x          = COORD_W'(x);
        r.y          = COORD_W'(y);
        r.z          = COORD_W'(z);
        r.side       = side;
        r.block_type = btype;
        pending_reqs.push_back(r);
        if (mode == MODE_WR_VOXEL)
            chunk_written[voxel_addr(x, y, z)] = 1'b1;
        if (mode == MODE_WR_NBR && side <= DIR_BACK)
            layer_written[layer_addr(int'(side), x, y, z)] = 1'b1;
        if (mode != MODE_UNUSED && !(mode == MODE_WR_NBR && side > DIR_BACK))
            counted_items++;
    endtask

    // Writes the voxel and all six of its neighbour cells with fixed types.
    task automatic surround(input int unsigned x, input int unsigned y, input int unsigned z,
                            input logic [TYPE_W-1:0] center, input logic [TYPE_W-1:0] layer_t,
                            input logic [TYPE_W-1:0] voxel_t);
        bit          on_layer;
        int unsigned nx;
        int unsigned ny;
        int unsigned nz;
        int unsigned addr;
        queue_request(MODE_WR_VOXEL, x, y, z, pick_side(), center);
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            locate_neighbour(x, y, z, DIR_W'(d), on_layer, nx, ny, nz, addr);
            if (on_layer)
                queue_request(MODE_WR_NBR, x, y, z, SIDE_W'(d), layer_t);
            else
                queue_request(MODE_WR_VOXEL, nx, ny, nz, pick_side(), voxel_t);
        end
    endtask

    // Fills in any of the seven cells a query reads that are still blank.
    task automatic prepare_query(input int unsigned x, input int unsigned y, input int unsigned z);
        bit          on_layer;
        int unsigned nx;
        int unsigned ny;
        int unsigned nz;
        int unsigned addr;
        if (!chunk_written[voxel_addr(x, y, z)])
            queue_request(MODE_WR_VOXEL, x, y, z, pick_side(), pick_type(20));
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            locate_neighbour(x, y, z, DIR_W'(d), on_layer, nx, ny, nz, addr);
            if (on_layer && !layer_written[addr])
                queue_request(MODE_WR_NBR, x, y, z, SIDE_W'(d), pick_type(50));
            else if (!on_layer && !chunk_written[addr])
                queue_request(MODE_WR_VOXEL, nx, ny, nz, pick_side(), pick_type(50));
        end
    endtask

    // Request driver: presents queued requests, then idles for the drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            tx_gap     = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                apply_request(req);
                if (req.mode == MODE_QUERY)
                    n_queries++;
                else if (req.mode == MODE_UNUSED || (req.mode == MODE_WR_NBR &&
                                                     req.side > DIR_BACK))
                    n_ignored++;
                else
                    n_writes++;
            end
            if (!req_valid || !req_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                    tx_gap     = idle_draw(sent_items);
                    sent_items++;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Face monitor: checks each accepted record and stalls at random, once for a
    // long stretch so the block backs up into its request side.
    always @(posedge clk or negedge rst_n)
    begin
        vfc_face_t want;
        if (!rst_n)
        begin
            face_stall <= 1'b0;
            rx_wait     = 0;
        end
        else
        begin
            if (face_valid && !face_stall)
            begin
                if (expected_faces.size() == 0)
                begin
                    $error("face record at (%0d,%0d,%0d) side %0d arrived with none expected",
                           face.face_x, face.face_y, face.face_z, face.face_side);
                    errors++;
                end
                else
                begin
                    want = expected_faces.pop_front();
                    if (face.face_x !== want.face_x)
                    begin
                        $error("face_x: expected %0d, actual %0d", want.face_x, face.face_x);
                        errors++;
                    end
                    if (face.face_y !== want.face_y)
                    begin
                        $error("face_y: expected %0d, actual %0d", want.face_y, face.face_y);
                        errors++;
                    end
                    if (face.face_z !== want.face_z)
                    begin
                        $error("face_z: expected %0d, actual %0d", want.face_z, face.face_z);
                        errors++;
                    end
                    if (face.face_side !== want.face_side)
                    begin
                        $error("face_side: expected %0d, actual %0d", want.face_side,
                               face.face_side);
                        errors++;
                    end
                    if (face.face_type !== want.face_type)
                    begin
                        $error("face_type: expected %0d, actual %0d", want.face_type,
                               face.face_type);
                        errors++;
                    end
                    if (face.last_face !== want.last_face)
                    begin
                        $error("last_face: expected %0d, actual %0d", want.last_face,
                               face.last_face);
                        errors++;
                    end
                end
                faces_seen++;
                rx_wait = idle_draw(faces_seen);
                if (!hold_done && faces_seen == HOLD_AT_FACE)
                begin
                    rx_wait   = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            else if (rx_wait > 0)
                rx_wait--;
            face_stall <= (rx_wait > 0);
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int unsigned x;
        int unsigned y;
        int unsigned z;
        int unsigned pick;

        // Corner voxel with all six neighbours air: six faces, boundary and chunk.
        surround(0, 0, 0, 8'hFF, 8'h00, 8'h00);
        queue_request(MODE_QUERY, 0, 0, 0, pick_side(), 8'h00);
        // Far corner completely enclosed: no faces, then open only its top.
        surround(EDGE_MAX, EDGE_MAX, EDGE_MAX, 8'h01, 8'hAA, 8'h01);
        queue_request(MODE_QUERY, EDGE_MAX, EDGE_MAX, EDGE_MAX, SIDE_UNUSED, 8'hFF);
        queue_request(MODE_WR_NBR, EDGE_MAX, EDGE_MAX, EDGE_MAX, DIR_TOP, 8'h00);
        queue_request(MODE_QUERY, EDGE_MAX, EDGE_MAX, EDGE_MAX, pick_side(), 8'h00);
        // Query on an air voxel gives nothing.
        queue_request(MODE_WR_VOXEL, 0, 0, 0, pick_side(), 8'h00);
        queue_request(MODE_QUERY, 0, 0, 0, pick_side(), 8'hFF);
        // Requests that the block must ignore: unused mode and out-of-range layers.
        queue_request(MODE_UNUSED, EDGE_MAX, EDGE_MAX, EDGE_MAX, SIDE_UNUSED, 8'hFF);
        queue_request(MODE_WR_NBR, EDGE_MAX, EDGE_MAX, EDGE_MAX, DIR_DONE, 8'h00);
        queue_request(MODE_WR_NBR, 0, 0, 0, SIDE_UNUSED, 8'hFF);

        // Random part: mostly prepared queries, plus stray writes and noise.
        while (counted_items < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            x = pick_coord();
            y = pick_coord();
            z = pick_coord();
            if (pick < 65)
            begin
                prepare_query(x, y, z);
                if ($urandom_range(0, 1) == 1)
                    queue_request(MODE_WR_VOXEL, x, y, z, pick_side(), pick_type(25));
                queue_request(MODE_QUERY, x, y, z, SIDE_W'($urandom_range(0, 7)),
                              TYPE_W'($urandom_range(0, 255)));
            end
            else if (pick < 80)
                queue_request(MODE_WR_VOXEL, x, y, z, SIDE_W'($urandom_range(0, 7)),
                              pick_type(40));
            else if (pick < 92)
                queue_request(MODE_WR_NBR, x, y, z, pick_side(), pick_type(50));
            else if (pick < 96)
                queue_request(MODE_UNUSED, x, y, z, SIDE_W'($urandom_range(0, 7)),
                              TYPE_W'($urandom_range(0, 255)));
            else
                queue_request(MODE_WR_NBR, x, y, z, SIDE_W'($urandom_range(6, 7)),
                              TYPE_W'($urandom_range(0, 255)));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_faces.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_faces.size() != 0)
        begin
            $error("%0d face records never arrived", expected_faces.size());
            errors++;
        end

        $display("Run covered %0d queries, %0d writes and %0d ignored requests,",
                 n_queries, n_writes, n_ignored);
        $display("checking %0d face records including a %0d-cycle output hold-off.",
                 faces_seen, HOLD_CYCLES);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #TIMEOUT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/vfc_pkg.sv
rtl/core/vfc_ram.sv
rtl/core/vfc_datapath.sv
rtl/core/vfc_ctrl.sv
rtl/core/voxel_face_culling_top.sv
test/tb_voxel_face_culling_top.sv
